/* design/min_max_feature_scaler_core_macros.svh */
`ifndef MIN_MAX_FEATURE_SCALER_CORE_MACROS_SVH
`define MIN_MAX_FEATURE_SCALER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MMFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MMFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mmfs_pkg.sv */
package mmfs_pkg;

  localparam int KIND_W   = 2;
  localparam int FEAT_W   = 6;
  localparam int NF_W     = 7;
  localparam int FRAC_W   = 5;
  localparam int FRAC_MAX = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [NF_W-1:0]   NF_RESET   = 7'd64;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;

  // config register select (byte address bit 2)
  localparam logic REG_NUM_FEATURES = 1'b0;
  localparam logic REG_FRAC_BITS    = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIT   = 2'd0,
    KIND_XFORM = 2'd1,
    KIND_INV   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_XFORM = 2'd1,
    OP_INV   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNFIT = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

  typedef enum logic [1:0] {
    F_SWEEP,
    F_IDLE,
    F_LOOK
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_PREP,
    B_DIV,
    B_MUL,
    B_SHIFT,
    B_FORM,
    B_CLAMP
  } back_state_t;

endpackage

/* design/mmfs_ram.sv */
module mmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mmfs_queue.sv */
`include "min_max_feature_scaler_core_macros.svh"

module mmfs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `MMFS_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full || pop, "queue push while full")
  `MMFS_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !empty, "queue pop while empty")

endmodule

/* design/mmfs_front.sv */
module mmfs_front
  import mmfs_pkg::*;
#(
  parameter int MAX_FEATURES = 64,
  parameter int VALUE_BITS   = 32,
  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int RW = 2 * VALUE_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  kind_t                        kind,
  input  logic [FEAT_W-1:0]            feature,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [NF_W-1:0]              num_features,
  input  logic                         q_full,
  output logic                         q_push,
  output cmd_ctrl_t                    q_ctrl,
  output logic [3*VALUE_BITS-1:0]      q_data
);

  front_state_t state, state_next;
  logic [AW-1:0] sweep_cnt, sweep_cnt_next;

  kind_t                        kind_r;
  logic [AW-1:0]                addr_r;
  logic signed [VALUE_BITS-1:0] x_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic                         rd_seen;
  logic signed [VALUE_BITS-1:0] rd_min, rd_max, new_min, new_max;
  logic                         accept, in_range;

  // table word: {seen, max, min}
  mmfs_ram #(.WIDTH(RW), .DEPTH(MAX_FEATURES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_seen = ram_rdata[RW-1];
  assign rd_max  = ram_rdata[2*VALUE_BITS-1:VALUE_BITS];
  assign rd_min  = ram_rdata[VALUE_BITS-1:0];

  assign s_tready = (state == F_IDLE) && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign in_range = (NF_W'(feature) < num_features) &&
                    (32'(feature) < 32'(MAX_FEATURES));

  always_comb begin
    if (!rd_seen) begin
      new_min = x_r;
      new_max = x_r;
    end else begin
      new_min = (x_r < rd_min) ? x_r : rd_min;
      new_max = (x_r > rd_max) ? x_r : rd_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_SWEEP;
      sweep_cnt <= '0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweep_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      addr_r <= AW'(feature);
      x_r    <= value;
    end
  end

  always_comb begin
    state_next     = state;
    sweep_cnt_next = sweep_cnt;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = {1'b1, new_max, new_min};
    ram_raddr      = AW'(feature);
    q_push         = 1'b0;
    q_ctrl         = '{op: OP_NONE, status: STAT_OK};
    q_data         = {x_r, rd_min, rd_max};
    unique case (state)
      F_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = '0;
        if (sweep_cnt == AW'(MAX_FEATURES - 1)) begin
          sweep_cnt_next = '0;
          state_next     = F_IDLE;
        end else begin
          sweep_cnt_next = sweep_cnt + 1'b1;
        end
      end
      F_IDLE: begin
        if (accept) begin
          if (kind == KIND_CLEAR) begin
            q_push     = 1'b1;
            state_next = F_SWEEP;
          end else if (!in_range) begin
            q_push        = 1'b1;
            q_ctrl.status = STAT_RANGE;
          end else begin
            state_next = F_LOOK;
          end
        end
      end
      F_LOOK: begin
        // table word for addr_r is on rdata this cycle
        q_push     = 1'b1;
        state_next = F_IDLE;
        case (kind_r) inside
          KIND_FIT: ram_we = 1'b1;
          KIND_XFORM, KIND_INV: begin
            if (!rd_seen) begin
              q_ctrl.status = STAT_UNFIT;
            end else begin
              q_ctrl.op = (kind_r == KIND_XFORM) ? OP_XFORM : OP_INV;
            end
          end
          default: ;
        endcase
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

/* design/mmfs_back.sv */
`include "min_max_feature_scaler_core_macros.svh"

module mmfs_back
  import mmfs_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  localparam int ND = VALUE_BITS + FRAC_MAX,
  localparam int CW = $clog2(ND),
  localparam int PW = 2 * VALUE_BITS,
  localparam int SW = (VALUE_BITS + 33 > PW + 1) ? VALUE_BITS + 33 : PW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  cmd_ctrl_t                    q_ctrl,
  input  logic [3*VALUE_BITS-1:0]      q_data,
  input  logic [FRAC_W-1:0]            frac_bits,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic signed [VALUE_BITS-1:0] result,
  output status_t                      status,
  output logic                         saturated
);

  localparam logic signed [VALUE_BITS-1:0] VHI = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VLO = {1'b1, {(VALUE_BITS-1){1'b0}}};

  back_state_t state, state_next;

  op_t                          op_r;
  status_t                      st_r;
  logic signed [VALUE_BITS-1:0] x_r, mn_r, mx_r;
  logic                         neg_r;
  logic [VALUE_BITS-1:0]        mag_r, r_r, rem_r;
  logic [ND-1:0]                num_r;
  logic [CW-1:0]                cnt_r;
  logic [PW-1:0]                prod_r, s_r;
  logic signed [SW-1:0]         acc_r;

  logic signed [VALUE_BITS:0]   r_wide, d_wide, x_wide;
  logic [VALUE_BITS-1:0]        r_val;
  logic [VALUE_BITS:0]          div_t;
  logic                         div_ge;
  logic                         low_nz;
  logic signed [SW-1:0]         q_round, s_signed;
  logic signed [VALUE_BITS-1:0] clamp_val;
  logic                         clamp_sat;
  logic                         slot_free;

  assign slot_free = !m_tvalid || m_tready;
  assign q_pop     = (state == B_IDLE) && !q_empty;

  assign r_wide = (VALUE_BITS+1)'(mx_r) - (VALUE_BITS+1)'(mn_r);
  assign d_wide = (VALUE_BITS+1)'(x_r) - (VALUE_BITS+1)'(mn_r);
  assign x_wide = (VALUE_BITS+1)'(x_r);
  assign r_val  = r_wide[VALUE_BITS-1:0];

  // restoring divider step, one quotient bit a cycle
  assign div_t  = {rem_r, num_r[ND-1]};
  assign div_ge = (div_t >= {1'b0, r_r});

  assign low_nz = |(prod_r & ~({PW{1'b1}} << frac_bits));

  assign q_round  = SW'(num_r) + SW'(neg_r && (rem_r != '0));
  assign s_signed = neg_r ? -SW'(s_r) : SW'(s_r);

  always_comb begin
    clamp_sat = 1'b0;
    clamp_val = acc_r[VALUE_BITS-1:0];
    if (acc_r > SW'(VHI)) begin
      clamp_sat = 1'b1;
      clamp_val = VHI;
    end else if (acc_r < SW'(VLO)) begin
      clamp_sat = 1'b1;
      clamp_val = VLO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_ctrl.op == OP_NONE) ? B_CLAMP : B_SETUP;
        end
      end
      B_SETUP: state_next = (op_r == OP_XFORM) ? B_PREP : B_MUL;
      B_PREP:  state_next = B_DIV;
      B_DIV: begin
        if (cnt_r == CW'(ND - 1)) begin
          state_next = B_FORM;
        end
      end
      B_MUL:   state_next = B_SHIFT;
      B_SHIFT: state_next = B_FORM;
      B_FORM:  state_next = B_CLAMP;
      B_CLAMP: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        op_r  <= q_ctrl.op;
        st_r  <= q_ctrl.status;
        x_r   <= q_data[3*VALUE_BITS-1 -: VALUE_BITS];
        mn_r  <= q_data[2*VALUE_BITS-1 -: VALUE_BITS];
        mx_r  <= q_data[VALUE_BITS-1:0];
        acc_r <= '0;
      end
      B_SETUP: begin
        r_r <= (r_val == '0) ? VALUE_BITS'(1) : r_val;
        if (op_r == OP_XFORM) begin
          neg_r <= d_wide[VALUE_BITS];
          mag_r <= d_wide[VALUE_BITS] ? VALUE_BITS'(-d_wide) : d_wide[VALUE_BITS-1:0];
        end else begin
          neg_r <= x_r[VALUE_BITS-1];
          mag_r <= x_r[VALUE_BITS-1] ? VALUE_BITS'(-x_wide) : x_wide[VALUE_BITS-1:0];
        end
      end
      B_PREP: begin
        num_r <= ND'(mag_r) << frac_bits;
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_DIV: begin
        rem_r <= div_ge ? VALUE_BITS'(div_t - {1'b0, r_r}) : div_t[VALUE_BITS-1:0];
        num_r <= {num_r[ND-2:0], div_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      B_MUL:   prod_r <= PW'(mag_r) * PW'(r_r);
      B_SHIFT: s_r <= (prod_r >> frac_bits) + PW'(neg_r && low_nz);
      B_FORM: begin
        // negative transforms round toward +inf on the magnitude
        if (op_r == OP_XFORM) begin
          acc_r <= neg_r ? -q_round : q_round;
        end else begin
          acc_r <= s_signed + SW'(mn_r);
        end
      end
      B_CLAMP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == B_CLAMP && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_CLAMP && slot_free) begin
      result    <= clamp_val;
      status    <= st_r;
      saturated <= clamp_sat;
    end
  end

  `MMFS_ASSERT_IMPLY(a_err_zero, clk, rst, m_tvalid && (status != STAT_OK), (result == '0) && !saturated, "error word carries data")
  `MMFS_ASSERT_IMPLY(a_rem_below, clk, rst, state == B_DIV, rem_r < r_r, "divider remainder not below range")
  `MMFS_ASSERT_NEXT(a_load_valid, clk, rst, (state == B_CLAMP) && slot_free, m_tvalid, "result load lost")

endmodule

/* design/min_max_feature_scaler_core.sv */
// Per-feature min/max scaler.
// Input stream: s_tuser = kind (0 fit, 1 transform, 2 inverse, 3 clear),
//   s_tdata = {pad, value, feature}. One result word per input word on the
//   output stream: m_tdata = result, m_tuser = {saturated, status}.
// Config over APB: num_features at 0x0, frac_bits at 0x4; write only when idle.
// Back end: a transform takes one quotient bit per cycle in the restoring
//   divider, VALUE_BITS+31 steps; an inverse takes one 32x32 multiply and
//   a shift; fit, unfitted, clear and out-of-range words skip both.
// Throughput: one item in flight in the back end; the front end can run up
//   to two items ahead through a two-entry queue.
// Reset: clears control state, then sweeps all MAX_FEATURES entries of the
//   feature table with s_tready low. A clear word triggers the same sweep
//   after its result is queued.
// Output stall: a finished result holds in the output register while
//   m_tready is low; the front end keeps accepting until the queue fills.
module min_max_feature_scaler_core
  import mmfs_pkg::*;
#(
  parameter int MAX_FEATURES = 64,
  parameter int VALUE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [5:0] feature, [37:6] value, [39:38] zero
  input  logic [1:0]  s_tuser,  // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] result
  output logic [2:0]  m_tuser,  // [1:0] status, [2] saturated
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = CTRL_W + 3 * VALUE_BITS;

  logic [NF_W-1:0]   num_features;
  logic [FRAC_W-1:0] frac_bits;
  logic              cfg_wr;

  logic                         q_push, q_pop, q_full, q_empty;
  cmd_ctrl_t                    push_ctrl;
  logic [3*VALUE_BITS-1:0]      push_data;
  logic [QW-1:0]                head;
  logic signed [VALUE_BITS-1:0] result;
  status_t                      status;
  logic                         saturated;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_features <= NF_RESET;
      frac_bits    <= FRAC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAC_BITS) begin
        frac_bits <= pwdata[FRAC_W-1:0];
      end else begin
        num_features <= pwdata[NF_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_FRAC_BITS) ? 32'(frac_bits) : 32'(num_features);

  mmfs_front #(.MAX_FEATURES(MAX_FEATURES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .kind         (kind_t'(s_tuser)),
    .feature      (s_tdata[FEAT_W-1:0]),
    .value        (s_tdata[FEAT_W +: VALUE_BITS]),
    .num_features (num_features),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ctrl       (push_ctrl),
    .q_data       (push_data)
  );

  mmfs_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_ctrl, push_data}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  mmfs_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctrl    (cmd_ctrl_t'(head[QW-1 -: CTRL_W])),
    .q_data    (head[3*VALUE_BITS-1:0]),
    .frac_bits (frac_bits),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result),
    .status    (status),
    .saturated (saturated)
  );

  assign m_tdata = 32'(result);
  assign m_tuser = {saturated, status};

endmodule

/* sim/scaler_checker.sv */
`timescale 1ns / 100ps

module scaler_checker
  import mmfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,  // [5:0] feature, [37:6] value, [39:38] zero
  input  logic [1:0]  s_tuser,  // [1:0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,  // [31:0] result
  input  logic [2:0]  m_tuser,  // [1:0] status, [2] saturated
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  localparam int FEATURES = 64;

  typedef struct {
    logic [31:0] result;
    status_t     status;
    logic        sat;
  } scaled_t;

  logic [NF_W-1:0]   nf;
  logic [FRAC_W-1:0] frac;
  longint            lo_bound [FEATURES];
  longint            hi_bound [FEATURES];
  logic              seen [FEATURES];
  scaled_t           predicted_words [$];

  // Works out the output word for one input word and updates the feature table.
  function automatic scaled_t scale_item(kind_t k, logic [FEAT_W-1:0] f, logic [31:0] raw);
    scaled_t   w;
    longint    x, mn, d, v;
    bit [63:0] r, mag, m, q, s;
    bit        neg;
    w.result = '0;
    w.status = STAT_OK;
    w.sat    = 1'b0;
    x = longint'($signed(raw));
    if (k == KIND_CLEAR) begin
      for (int i = 0; i < FEATURES; i++) seen[i] = 1'b0;
    end else if ({1'b0, f} >= nf) begin
      w.status = STAT_RANGE;
    end else if (k == KIND_FIT) begin
      if (!seen[f]) begin
        lo_bound[f] = x;
        hi_bound[f] = x;
        seen[f]     = 1'b1;
      end else begin
        if (x < lo_bound[f]) lo_bound[f] = x;
        if (x > hi_bound[f]) hi_bound[f] = x;
      end
    end else if (!seen[f]) begin
      w.status = STAT_UNFIT;
    end else begin
      mn = lo_bound[f];
      r  = hi_bound[f] - mn;
      if (r == 0) r = 1;
      if (k == KIND_XFORM) begin
        d   = x - mn;
        neg = d < 0;
        mag = neg ? -d : d;
        m   = mag << frac;
        // negative side rounds the magnitude up so the signed result is floored
        q   = neg ? (m + r - 1) / r : m / r;
        if (neg) begin
          if (q > 64'h8000_0000) begin
            w.sat    = 1'b1;
            w.result = 32'h8000_0000;
          end else begin
            q        = 0 - q;
            w.result = q[31:0];
          end
        end else if (q > 64'h7fff_ffff) begin
          w.sat    = 1'b1;
          w.result = 32'h7fff_ffff;
        end else begin
          w.result = q[31:0];
        end
      end else begin
        neg = x < 0;
        mag = neg ? -x : x;
        m   = mag * r;
        s   = neg ? (m + ((64'd1 << frac) - 1)) >> frac : m >> frac;
        v   = (neg ? -$signed(s) : $signed(s)) + mn;
        if (v > 64'sd2147483647) begin
          w.sat    = 1'b1;
          w.result = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
          w.sat    = 1'b1;
          w.result = 32'h8000_0000;
        end else begin
          w.result = v[31:0];
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    scaled_t want;
    if (rst) begin
      nf   = NF_RESET;
      frac = FRAC_RESET;
      for (int i = 0; i < FEATURES; i++) seen[i] = 1'b0;
      predicted_words.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FRAC_BITS) frac = pwdata[FRAC_W-1:0];
        else nf = pwdata[NF_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (predicted_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output word: result %h status %0d sat %0d",
                     m_tdata, m_tuser[1:0], m_tuser[2]);
        end else begin
          want = predicted_words.pop_front();
          if (m_tdata !== want.result || m_tuser[1:0] !== want.status ||
              m_tuser[2] !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("word mismatch: result exp %h got %h, status exp %0d got %0d, sat exp %0d got %0d",
                       want.result, m_tdata, want.status, m_tuser[1:0], want.sat, m_tuser[2]);
          end
        end
      end
      if (s_tvalid && s_tready)
        predicted_words.push_back(scale_item(kind_t'(s_tuser), s_tdata[5:0], s_tdata[37:6]));
    end
    pending = predicted_words.size();
  end

endmodule

/* sim/tb_min_max_feature_scaler_core.sv */
`timescale 1ns / 100ps

module tb_min_max_feature_scaler_core;
  import mmfs_pkg::*;

  localparam int LIMIT  = 1000000;
  localparam int SETTLE = 150;  // longest transform plus a clear sweep, with margin
  localparam int PHASES = 9;
  // -1 picks a random legal setting
  localparam int NF_TAB [PHASES]   = '{64, 1, 127, 0, -1, 64, 33, -1, 64};
  localparam int FRAC_TAB [PHASES] = '{16, 0, 31, 30, -1, 31, 0, -1, 16};

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [5:0] feature, [37:6] value, [39:38] zero
  logic [1:0]  s_tuser;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] result
  logic [2:0]  m_tuser;   // [1:0] status, [2] saturated
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int src_idle = 34;
  int dst_idle = 49;
  int cycles = 0;
  int fail_count;
  int pending;
  int nf_now;
  int frac_now;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  min_max_feature_scaler_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  scaler_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(kind_t k, logic [5:0] f, logic [31:0] v);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, v, f};
    s_tuser  <= k;
    // ready is stable mid-cycle; the word goes in at the following edge
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_feature();
    int last;
    int roll;
    last = (nf_now == 0) ? 0 : ((nf_now > 64) ? 63 : nf_now - 1);
    roll = $urandom_range(0, 99);
    // mostly a few hot features so fits and transforms meet
    if (roll < 60) return 6'($urandom_range(0, (last < 7) ? last : 7));
    if (roll < 85) return 6'($urandom_range(0, last));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [31:0] pick_value(kind_t k);
    int          roll;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    if (k == KIND_INV && roll < 40) begin
      v = $urandom_range(0, 32'h1 << frac_now);  // zero to one in Qfrac
    end else if (roll < 55) begin
      v = $urandom_range(0, 10000) - 5000;
    end else if (roll < 75) begin
      v = $urandom;
    end else if (roll < 88) begin
      v = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 4))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        default: v = 32'h0000_0001;
      endcase
    end
    return v;
  endfunction

  // runs with 64 features and 16 fraction bits
  task automatic directed_words();
    send_word(KIND_XFORM, 6'd0, 32'd5);          // not fitted yet
    send_word(KIND_INV,   6'd0, 32'd5);
    send_word(KIND_FIT,   6'd0, 32'd100);        // first sample sets both bounds
    send_word(KIND_XFORM, 6'd0, 32'd100);        // zero range
    send_word(KIND_XFORM, 6'd0, 32'h7fff_ffff);  // clamps high
    send_word(KIND_XFORM, 6'd0, 32'h8000_0000);  // clamps low
    send_word(KIND_FIT,   6'd0, 32'd300);
    send_word(KIND_FIT,   6'd0, -32'sd50);
    send_word(KIND_XFORM, 6'd0, 32'd125);
    send_word(KIND_XFORM, 6'd0, -32'sd51);       // negative, floored
    send_word(KIND_INV,   6'd0, 32'h0000_8000);
    send_word(KIND_INV,   6'd0, -32'sd65536);
    send_word(KIND_INV,   6'd0, 32'hffff_ffff);
    send_word(KIND_FIT,   6'd63, 32'h8000_0000);
    send_word(KIND_FIT,   6'd63, 32'h7fff_ffff); // full 32-bit range
    send_word(KIND_INV,   6'd63, 32'h7fff_ffff);
    send_word(KIND_INV,   6'd63, 32'h8000_0000);
    send_word(KIND_XFORM, 6'd63, 32'd0);
    send_word(KIND_CLEAR, 6'd42, 32'h1234_5678);
    send_word(KIND_XFORM, 6'd63, 32'd0);
    send_word(KIND_INV,   6'd0, 32'd0);
    send_word(KIND_FIT,   6'd0, 32'd7);
  endtask

  initial begin
    int    n_words;
    int    roll;
    kind_t k;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= KIND_FIT;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);  // table sweep after reset

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) drain();
      case (p / 3)
        0: begin src_idle = 34; dst_idle = 49; end
        1: begin src_idle = 49; dst_idle = 34; end
        default: begin src_idle = 0; dst_idle = 0; end
      endcase
      nf_now   = (NF_TAB[p] < 0) ? $urandom_range(1, 64) : NF_TAB[p];
      frac_now = (FRAC_TAB[p] < 0) ? $urandom_range(0, 31) : FRAC_TAB[p];
      cfg_write({REG_NUM_FEATURES, 2'b00}, nf_now);
      cfg_write({REG_FRAC_BITS, 2'b00}, frac_now);
      if (p == 0) directed_words();

      n_words = (nf_now == 0) ? 40 : 140;
      for (int i = 0; i < n_words; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 38) k = KIND_FIT;
        else if (roll < 70) k = KIND_XFORM;
        else if (roll < 97) k = KIND_INV;
        else k = KIND_CLEAR;
        send_word(k, pick_feature(), pick_value(k));
      end
    end

    s_tvalid <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
